/* src/dcs_pkg.sv */
package dcs_pkg;

  typedef struct packed {
    logic [1:0]  req_type;
    logic [31:0] delay_ms;
    logic [7:0]  handle;
  } req_t;

  typedef struct packed {
    logic [7:0] fired_handle;
    logic       fired;
    logic       last;
    logic       status;
  } rsp_t;

  localparam logic [1:0] REQ_TICK     = 2'd0;
  localparam logic [1:0] REQ_REGISTER = 2'd1;
  localparam logic [1:0] REQ_SERVICE  = 2'd2;

  localparam logic STATUS_OK   = 1'b0;
  localparam logic STATUS_FULL = 1'b1;

  localparam int HANDLE_W = 8;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_REG,
    ST_SCAN,
    ST_EMIT,
    ST_NONE,
    ST_PACK
  } state_t;

endpackage

/* src/dcs_table.sv */
module dcs_table #(
  parameter int DEPTH = 32,
  parameter int WIDTH = 41
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

/* src/dcs_ctrl.sv */
module dcs_ctrl #(
  parameter int TABLE_DEPTH = 32,
  parameter int TICK_WIDTH  = 32
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           req_valid,
  output logic                           req_stall,
  input  dcs_pkg::req_t                  req,
  input  logic                           slot_free,
  output logic                           emit,
  output dcs_pkg::rsp_t                  emit_word,
  output logic                           mem_we,
  output logic [$clog2(TABLE_DEPTH)-1:0] mem_waddr,
  output logic [TICK_WIDTH+dcs_pkg::HANDLE_W:0] mem_wdata,
  output logic [$clog2(TABLE_DEPTH)-1:0] mem_raddr,
  input  logic [TICK_WIDTH+dcs_pkg::HANDLE_W:0] mem_rdata
);

  localparam int AW = $clog2(TABLE_DEPTH);
  localparam int CW = $clog2(TABLE_DEPTH + 1);
  localparam int HW = dcs_pkg::HANDLE_W;
  localparam int EW = TICK_WIDTH + HW + 1;

  dcs_pkg::state_t state, state_next;

  logic [TICK_WIDTH-1:0] tick_count;
  logic [CW-1:0]         entry_count;
  logic [CW-1:0]         rd_idx;
  logic                  rd_pend;
  logic [AW-1:0]         rd_pend_idx;
  logic [CW-1:0]         keep;
  logic [CW-1:0]         n_due;
  logic                  best_found;
  logic [AW-1:0]         best_idx;
  logic [TICK_WIDTH-1:0] best_dl;
  logic [HW-1:0]         best_h;
  logic                  first_pass;
  logic [31:0]           reg_delay;
  logic [HW-1:0]         reg_handle;

  logic                  accept;
  logic                  full;
  logic                  issue;
  logic                  scan_done;
  logic                  rd_mark;
  logic [TICK_WIDTH-1:0] rd_dl;
  logic [HW-1:0]         rd_h;
  logic                  due;
  logic                  take;
  logic                  last_due;
  logic [TICK_WIDTH-1:0] new_dl;

  // entry word: {removed mark, deadline, handle}
  assign rd_mark = mem_rdata[EW-1];
  assign rd_dl   = mem_rdata[EW-2:HW];
  assign rd_h    = mem_rdata[HW-1:0];

  assign accept    = req_valid && !req_stall;
  assign full      = entry_count >= CW'(TABLE_DEPTH);
  assign issue     = (state == dcs_pkg::ST_SCAN || state == dcs_pkg::ST_PACK) &&
                     (rd_idx != entry_count);
  assign scan_done = (rd_idx == entry_count) && !rd_pend;
  assign due       = rd_pend && !rd_mark && (rd_dl <= tick_count);
  // strict compare keeps the earlier entry on equal deadlines
  assign take      = due && (!best_found || (rd_dl < best_dl));
  assign last_due  = n_due == CW'(1);
  assign new_dl    = tick_count + TICK_WIDTH'(reg_delay);

  always_comb begin
    state_next = state;
    case (state)
      dcs_pkg::ST_IDLE: begin
        if (accept && req.req_type == dcs_pkg::REQ_REGISTER) begin
          state_next = dcs_pkg::ST_REG;
        end else if (accept && req.req_type == dcs_pkg::REQ_SERVICE) begin
          state_next = dcs_pkg::ST_SCAN;
        end
      end
      dcs_pkg::ST_REG: begin
        if (slot_free) state_next = dcs_pkg::ST_IDLE;
      end
      dcs_pkg::ST_SCAN: begin
        if (scan_done) begin
          if (best_found) begin
            state_next = dcs_pkg::ST_EMIT;
          end else if (first_pass) begin
            state_next = dcs_pkg::ST_NONE;
          end else begin
            state_next = dcs_pkg::ST_PACK;
          end
        end
      end
      dcs_pkg::ST_EMIT: begin
        if (slot_free) state_next = last_due ? dcs_pkg::ST_PACK : dcs_pkg::ST_SCAN;
      end
      dcs_pkg::ST_NONE: begin
        if (slot_free) state_next = dcs_pkg::ST_IDLE;
      end
      dcs_pkg::ST_PACK: begin
        if (scan_done) state_next = dcs_pkg::ST_IDLE;
      end
      default: state_next = dcs_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    req_stall = state != dcs_pkg::ST_IDLE;
    emit      = 1'b0;
    emit_word = '{fired_handle: '0, fired: 1'b0, last: 1'b1, status: dcs_pkg::STATUS_OK};
    mem_we    = 1'b0;
    mem_waddr = entry_count[AW-1:0];
    mem_wdata = {1'b0, new_dl, reg_handle};
    mem_raddr = rd_idx[AW-1:0];
    case (state)
      dcs_pkg::ST_REG: begin
        emit = slot_free;
        mem_we = slot_free && !full;
        if (full) emit_word.status = dcs_pkg::STATUS_FULL;
      end
      dcs_pkg::ST_EMIT: begin
        emit = slot_free;
        emit_word = '{fired_handle: best_h, fired: 1'b1, last: last_due,
                      status: dcs_pkg::STATUS_OK};
        // mark the reported entry; compaction drops it later
        mem_we    = slot_free;
        mem_waddr = best_idx;
        mem_wdata = {1'b1, best_dl, best_h};
      end
      dcs_pkg::ST_NONE: begin
        emit = slot_free;
      end
      dcs_pkg::ST_PACK: begin
        mem_we    = rd_pend && !rd_mark;
        mem_waddr = keep[AW-1:0];
        mem_wdata = mem_rdata;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= dcs_pkg::ST_IDLE;
      tick_count  <= '0;
      entry_count <= '0;
      rd_idx      <= '0;
      rd_pend     <= 1'b0;
      keep        <= '0;
      n_due       <= '0;
      best_found  <= 1'b0;
      first_pass  <= 1'b0;
    end else begin
      state       <= state_next;
      rd_pend     <= issue;
      rd_pend_idx <= rd_idx[AW-1:0];
      if (issue) rd_idx <= rd_idx + CW'(1);
      case (state)
        dcs_pkg::ST_IDLE: begin
          if (accept) begin
            reg_delay  <= req.delay_ms;
            reg_handle <= req.handle;
            if (req.req_type == dcs_pkg::REQ_TICK) tick_count <= tick_count + 1'b1;
            rd_idx     <= '0;
            n_due      <= '0;
            best_found <= 1'b0;
            first_pass <= 1'b1;
          end
        end
        dcs_pkg::ST_REG: begin
          if (slot_free && !full) entry_count <= entry_count + CW'(1);
        end
        dcs_pkg::ST_SCAN: begin
          if (due) n_due <= n_due + CW'(1);
          if (take) begin
            best_found <= 1'b1;
            best_idx   <= rd_pend_idx;
            best_dl    <= rd_dl;
            best_h     <= rd_h;
          end
          if (scan_done) begin
            rd_idx <= '0;
            keep   <= '0;
          end
        end
        dcs_pkg::ST_EMIT: begin
          if (slot_free) begin
            rd_idx     <= '0;
            keep       <= '0;
            n_due      <= '0;
            best_found <= 1'b0;
            first_pass <= 1'b0;
          end
        end
        dcs_pkg::ST_PACK: begin
          if (rd_pend && !rd_mark) keep <= keep + CW'(1);
          if (scan_done) entry_count <= keep;
        end
        default: begin
        end
      endcase
    end
  end

  a_last_goes_to_pack: assert property (@(posedge clk) disable iff (rst)
    (state == dcs_pkg::ST_EMIT && slot_free && last_due) |=> state == dcs_pkg::ST_PACK)
    else $error("last fired word not followed by compaction");

  a_no_write_in_scan: assert property (@(posedge clk) disable iff (rst)
    (state == dcs_pkg::ST_SCAN) |-> !mem_we)
    else $error("table written during scan");

  a_count_stable: assert property (@(posedge clk) disable iff (rst)
    (state != dcs_pkg::ST_REG && state != dcs_pkg::ST_PACK) |=> $stable(entry_count))
    else $error("entry count changed outside register or compaction");

  a_emit_has_best: assert property (@(posedge clk) disable iff (rst)
    (state == dcs_pkg::ST_EMIT) |-> (best_found && n_due != '0))
    else $error("fire state without a due entry");

  a_keep_behind_read: assert property (@(posedge clk) disable iff (rst)
    (state == dcs_pkg::ST_PACK) |-> (keep <= rd_idx && rd_idx <= entry_count))
    else $error("compaction write pointer ahead of read pointer");

endmodule

/* src/deadline_callback_scheduler.sv */
// Tick: accepted while idle, no result word. Register: the result word follows the register state.
// Service over N entries with k due: k scan passes, each followed by a fire state that
// reports one entry, then a compaction pass; if none is due, one scan pass and a no-fire word.
// One item at a time; the single-port-read entry table sets the pace of every pass.
// Synchronous reset clears counter, entry count and control; table contents are not cleared.
module deadline_callback_scheduler #(
  parameter int TABLE_DEPTH = 32,
  parameter int TICK_WIDTH  = 32
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          req_valid,
  output logic          req_stall,
  input  dcs_pkg::req_t req,
  output logic          rsp_valid,
  input  logic          rsp_stall,
  output dcs_pkg::rsp_t rsp
);

  localparam int AW = $clog2(TABLE_DEPTH);
  localparam int EW = TICK_WIDTH + dcs_pkg::HANDLE_W + 1;

  logic          slot_free;
  logic          emit;
  dcs_pkg::rsp_t emit_word;
  logic          mem_we;
  logic [AW-1:0] mem_waddr;
  logic [EW-1:0] mem_wdata;
  logic [AW-1:0] mem_raddr;
  logic [EW-1:0] mem_rdata;

  assign slot_free = !rsp_valid || !rsp_stall;

  dcs_ctrl #(
    .TABLE_DEPTH(TABLE_DEPTH),
    .TICK_WIDTH (TICK_WIDTH)
  ) u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .req_valid(req_valid),
    .req_stall(req_stall),
    .req      (req),
    .slot_free(slot_free),
    .emit     (emit),
    .emit_word(emit_word),
    .mem_we   (mem_we),
    .mem_waddr(mem_waddr),
    .mem_wdata(mem_wdata),
    .mem_raddr(mem_raddr),
    .mem_rdata(mem_rdata)
  );

  dcs_table #(
    .DEPTH(TABLE_DEPTH),
    .WIDTH(EW)
  ) u_table (
    .clk  (clk),
    .we   (mem_we),
    .waddr(mem_waddr),
    .wdata(mem_wdata),
    .raddr(mem_raddr),
    .rdata(mem_rdata)
  );

  // output word register
  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (emit) begin
      rsp_valid <= 1'b1;
    end else if (!rsp_stall) begin
      rsp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      rsp <= emit_word;
    end
  end

endmodule
